@@ hdl/dqpf_pkg.sv @@
// ----------------------------------------------------------------------------
// dqpf_pkg
// Shared widths, request and status codes, and the controller/datapath
// command and status groups for the parity-filter deque.
// ----------------------------------------------------------------------------
package dqpf_pkg;

   localparam int REQ_W   = 3;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 6;

   // Request codes; codes five to seven are treated as no-ops.
   typedef enum logic [REQ_W-1:0] {
      REQ_CREATE = 3'd0,
      REQ_ADD    = 3'd1,
      REQ_VIEW   = 3'd2,
      REQ_CLEAR  = 3'd3,
      REQ_REMOVE = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_REFUSED = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // Controller -> datapath
   typedef struct packed {
      logic run_single;
      logic start_walk;
      logic view_step;
      logic filter_step;
      logic filter_finish;
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic list_empty;
      logic out_free;
      logic view_done;
      logic filter_done;
   } stat_type;

endpackage

@@ hdl/dqpf_stream_if.sv @@
// ----------------------------------------------------------------------------
// dqpf_req_if / dqpf_rsp_if
// Valid/ready channels for requests and results of the parity-filter deque.
// ----------------------------------------------------------------------------
interface dqpf_req_if;
   logic                              valid;
   logic                              ready;
   logic [dqpf_pkg::REQ_W-1:0]        req_type;
   logic signed [dqpf_pkg::DATA_W-1:0] value;
   logic                              end_select;
   logic                              remove_even;

   modport source (output valid, req_type, value, end_select, remove_even,
                   input ready);
   modport sink   (input valid, req_type, value, end_select, remove_even,
                   output ready);
endinterface

interface dqpf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [dqpf_pkg::DATA_W-1:0] elem_value;
   logic                               last;
   logic [1:0]                         status;
   logic [dqpf_pkg::COUNT_W-1:0]       elem_count;

   modport source (output valid, elem_value, last, status, elem_count,
                   input ready);
   modport sink   (input valid, elem_value, last, status, elem_count,
                   output ready);
endinterface

@@ hdl/dqpf_ctrl.sv @@
// ----------------------------------------------------------------------------
// dqpf_ctrl
// Request sequencer: takes requests in idle, runs the view and parity-filter
// walks over the ring store and tells the datapath what to do each cycle.
// ----------------------------------------------------------------------------
module dqpf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [dqpf_pkg::REQ_W-1:0] req_code,
   input  dqpf_pkg::stat_type         stat,
   output logic                       req_ready,
   output dqpf_pkg::cmd_type          cmd
);
   import dqpf_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_VIEW,
      S_FILTER
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               if (req_code == REQ_VIEW && !stat.list_empty) begin
                  cmd.start_walk = 1'b1;
                  state_in       = S_VIEW;
               end else if (req_code == REQ_REMOVE && !stat.list_empty) begin
                  cmd.start_walk = 1'b1;
                  state_in       = S_FILTER;
               end else begin
                  cmd.run_single = 1'b1;
               end
            end
         end
         S_VIEW: begin
            cmd.view_step = 1'b1;
            if (stat.view_done) begin
               state_in = S_IDLE;
            end
         end
         S_FILTER: begin
            if (stat.filter_done) begin
               cmd.filter_finish = 1'b1;
               state_in          = S_IDLE;
            end else begin
               cmd.filter_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/dqpf_datapath.sv @@
// ----------------------------------------------------------------------------
// dqpf_datapath
// Ring store, front index, element count, walk counters, read register and
// the result register.
// ----------------------------------------------------------------------------
module dqpf_datapath #(
   parameter int DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [dqpf_pkg::REQ_W-1:0]         req_code,
   input  logic signed [dqpf_pkg::DATA_W-1:0] req_value,
   input  logic                               req_end_select,
   input  logic                               req_remove_even,
   input  dqpf_pkg::cmd_type                  cmd,
   output dqpf_pkg::stat_type                 stat,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic signed [dqpf_pkg::DATA_W-1:0] rsp_elem_value,
   output logic                               rsp_last,
   output logic [1:0]                         rsp_status,
   output logic [dqpf_pkg::COUNT_W-1:0]       rsp_elem_count
);
   import dqpf_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_W-1:0] mem [DEPTH];

   logic [IDX_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  keep_ff, keep_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_last_ff, rd_last_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic              back_ff, back_in;
   logic              rem_even_ff, rem_even_in;

   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   logic              out_last_ff, out_last_in;
   status_type        out_status_ff, out_status_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   logic              out_free, pos_end, move, issue, keep_it;
   logic [CNT_W-1:0]  view_pos;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              wr_en;
   status_type        single_status;

   // Slot of element p counted from base, wrapping at DEPTH.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] p);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(p);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign out_free = !out_valid_ff || rsp_ready;
   assign pos_end  = (pos_ff == count_ff);
   assign move     = cmd.view_step && rd_pend_ff && out_free;
   assign issue    = (cmd.view_step && !pos_end && (!rd_pend_ff || move)) ||
                     (cmd.filter_step && !pos_end);
   assign keep_it  = cmd.filter_step && rd_pend_ff && (rd_data_ff[0] == rem_even_ff);
   assign view_pos = back_ff ? (count_ff - pos_ff - CNT_W'(1)) : pos_ff;
   assign rd_addr  = slot_of(front_ff, cmd.view_step ? view_pos : pos_ff);

   assign stat.list_empty  = (count_ff == '0);
   assign stat.out_free    = out_free;
   assign stat.view_done   = pos_end && (!rd_pend_ff || move);
   assign stat.filter_done = pos_end && !rd_pend_ff;

   // State updates and store writes
   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_of(front_ff, keep_ff);
      wr_data       = rd_data_ff;
      single_status = ST_OK;
      if (cmd.run_single) begin
         case (req_code)
            REQ_CREATE: begin
               if (count_ff != '0) begin
                  single_status = ST_REFUSED;
               end else begin
                  front_in = '0;
                  count_in = CNT_W'(1);
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = req_value;
               end
            end
            REQ_ADD: begin
               if (count_ff == '0) begin
                  single_status = ST_EMPTY;
               end else if (count_ff >= CNT_W'(DEPTH)) begin
                  single_status = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = req_value;
                  count_in = count_ff + CNT_W'(1);
                  if (!req_end_select) begin
                     front_in = (front_ff == '0) ? IDX_W'(DEPTH - 1)
                                                 : front_ff - IDX_W'(1);
                     wr_addr  = front_in;
                  end else begin
                     wr_addr = slot_of(front_ff, count_ff);
                  end
               end
            end
            REQ_VIEW, REQ_REMOVE: begin
               // only reached as a single op on an empty list
               single_status = ST_EMPTY;
            end
            REQ_CLEAR: begin
               front_in = '0;
               count_in = '0;
            end
            default: begin
               single_status = ST_OK;
            end
         endcase
      end
      if (keep_it) begin
         wr_en = 1'b1;
      end
      if (cmd.filter_finish) begin
         count_in = keep_ff;
         if (keep_ff == '0) begin
            front_in = '0;
         end
      end
   end

   // Walk counters
   always_comb begin
      pos_in      = pos_ff;
      keep_in     = keep_ff;
      rd_pend_in  = rd_pend_ff;
      rd_last_in  = rd_last_ff;
      back_in     = back_ff;
      rem_even_in = rem_even_ff;
      if (cmd.start_walk) begin
         pos_in      = '0;
         keep_in     = '0;
         rd_pend_in  = 1'b0;
         back_in     = req_end_select;
         rem_even_in = req_remove_even;
      end else begin
         if (issue) begin
            pos_in     = pos_ff + CNT_W'(1);
            rd_pend_in = 1'b1;
            rd_last_in = (pos_ff + CNT_W'(1) == count_ff);
         end else if (move || cmd.filter_step) begin
            rd_pend_in = 1'b0;
         end
         if (keep_it) begin
            keep_in = keep_ff + CNT_W'(1);
         end
      end
   end

   // Result register
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      if (cmd.run_single || cmd.filter_finish || move) begin
         out_valid_in  = 1'b1;
         out_value_in  = move ? rd_data_ff : '0;
         out_last_in   = move ? rd_last_ff : 1'b1;
         out_status_in = cmd.run_single ? single_status : ST_OK;
         out_count_in  = COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         keep_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         keep_ff      <= keep_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_last_ff    <= rd_last_in;
      back_ff       <= back_in;
      rem_even_ff   <= rem_even_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_elem_value = out_value_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_elem_count = out_count_ff;

endmodule

@@ hdl/deque_with_parity_filter.sv @@
// ----------------------------------------------------------------------------
// deque_with_parity_filter
// Bounded double-ended list of signed 32-bit values in a DEPTH-entry ring
// store, with view in either direction and removal of even or odd values.
// Results: create, add, clear and refused requests give their result in the
//   cycle after the transfer; view passes its first element through the read
//   register and then the result register.
// Throughput, while results are taken: single-result requests one per cycle;
//   view and parity removal take no new request until the walk over the n
//   stored elements, one per cycle on the store's one read port, is done.
// Reset clears the list (count and front index zero); store
//   contents are not cleared.
// ----------------------------------------------------------------------------
module deque_with_parity_filter #(
   parameter int DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   dqpf_req_if.sink    req_chan,
   dqpf_rsp_if.source  rsp_chan
);
   import dqpf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dqpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_code  (req_chan.req_type),
      .stat      (stat),
      .req_ready (req_chan.ready),
      .cmd       (cmd)
   );

   dqpf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_code        (req_chan.req_type),
      .req_value       (req_chan.value),
      .req_end_select  (req_chan.end_select),
      .req_remove_even (req_chan.remove_even),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_elem_value  (rsp_chan.elem_value),
      .rsp_last        (rsp_chan.last),
      .rsp_status      (rsp_chan.status),
      .rsp_elem_count  (rsp_chan.elem_count)
   );

endmodule

@@ hdl/dqpf_checker.sv @@
// ----------------------------------------------------------------------------
// dqpf_checker
// Port-level checks for the parity-filter deque, bound to the top level.
// ----------------------------------------------------------------------------
module dqpf_checker #(
   parameter int DEPTH = 32
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [dqpf_pkg::REQ_W-1:0]         req_type,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [dqpf_pkg::DATA_W-1:0] rsp_elem_value,
   input logic                               rsp_last,
   input logic [1:0]                         rsp_status,
   input logic [dqpf_pkg::COUNT_W-1:0]       rsp_elem_count
);
   import dqpf_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_elem_value) &&
         $stable(rsp_last) && $stable(rsp_status) && $stable(rsp_elem_count))
      else $error("result changed while stalled");

   // only a view streams several results, and all of them are ok
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ST_OK)
      else $error("non-final result with error status");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_elem_value == '0)
      else $error("error result carries a value");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_elem_count) <= 32'(DEPTH))
      else $error("element count above capacity");

   a_single_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
         (req_type == REQ_CREATE || req_type == REQ_ADD || req_type == REQ_CLEAR)
      |=> rsp_valid && rsp_last)
      else $error("single-result request gave no result next cycle");

endmodule

bind deque_with_parity_filter dqpf_checker #(
   .DEPTH (DEPTH)
) u_dqpf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_type       (req_chan.req_type),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_elem_value (rsp_chan.elem_value),
   .rsp_last       (rsp_chan.last),
   .rsp_status     (rsp_chan.status),
   .rsp_elem_count (rsp_chan.elem_count)
);
